// ----- hdl/n_queens_backtrack_solver_core_defines.svh -----
// Assertion macros for the checker file of this block.
`ifndef N_QUEENS_BACKTRACK_SOLVER_CORE_DEFINES_SVH
`define N_QUEENS_BACKTRACK_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NQBS_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NQBS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- hdl/nqbs_pkg.sv -----
package nqbs_pkg;

    // Width of a board size, a row number and an output column.
    localparam int unsigned FIELD_W = 5;
    // Candidate columns run one past the board size, so they need one more bit.
    localparam int unsigned COL_W = FIELD_W + 1;
    // Byte-padded widths of the stream data buses.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRY,
        ST_CHECK,
        ST_BACK_LD,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT_WAIT
    } state_t;

    // Operands of the attack test: candidate column, the column of an earlier
    // queen, and the row distance between the two.
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   other;
        logic [FIELD_W-1:0] drow;
    } chk_req_t;

endpackage

// ----- hdl/n_queens_backtrack_solver_core.sv -----
// N-queens first-solution search engine.
// The slave stream takes one request: s_tdata[4:0] is the board size n. The
// block is ready only while idle, so s_tready drops for the whole search.
// For a board with a solution the master stream carries n items, one per
// row from row 1 upward, each holding the row, the queen's column and
// found = 1; m_tlast marks the item of row n. Boards of size 0, 2, 3 or
// above MAX_QUEENS give a single item with all fields zero, found = 0 and
// m_tlast set.
// The search runs on one attack-test unit. Testing one candidate column
// takes a try step plus one check step per earlier row compared against it,
// and backing up a row takes a try step and a reload step, so large boards
// search far longer than small ones. The column memory is read through
// its single registered port, one earlier row per cycle, and that port sets
// the pace. Each result item then passes through a read state, a load state
// and a wait state that holds until m_tready is high.
// Results leave from an output register that holds steady while m_tready is
// low; the search is already finished then and simply waits. A synchronous
// active-low reset returns the sequencer to idle and drops m_tvalid; the
// column memory needs no clearing because every entry is written before read.
module n_queens_backtrack_solver_core #(
    parameter int unsigned MAX_QUEENS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nqbs_pkg::S_TDATA_W-1:0] s_tdata,   // [4:0] board_size
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nqbs_pkg::M_TDATA_W-1:0] m_tdata,   // [4:0] row, [9:5] column, [10] found
    output logic                           m_tlast    // last
);

    localparam int unsigned ADDR_W = $clog2(MAX_QUEENS);
    localparam int unsigned FW     = nqbs_pkg::FIELD_W;
    localparam int unsigned CW     = nqbs_pkg::COL_W;

    nqbs_pkg::state_t state_reg, state_next;

    logic [FW-1:0] n_reg, n_next;      // board size of the current request
    logic [FW-1:0] k_reg, k_next;      // row being placed, 1-based
    logic [FW-1:0] i_reg, i_next;      // earlier row under comparison, 1-based
    logic [CW-1:0] col_reg, col_next;  // candidate column for row k
    logic [FW-1:0] r_reg, r_next;      // row being emitted, 1-based

    logic          m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0] row_reg, row_next;
    logic [FW-1:0] column_reg, column_next;
    logic          found_reg, found_next;
    logic          last_reg, last_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CW-1:0]     wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CW-1:0]     rd_data;

    nqbs_pkg::chk_req_t chk_req;
    logic               conflict;

    logic [FW-1:0] in_size;

    assign in_size = s_tdata[FW-1:0];

    nqbs_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_QUEENS)
    ) u_columns (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The read data belongs to earlier row i; compare it with the candidate.
    assign chk_req.col   = col_reg;
    assign chk_req.other = rd_data;
    assign chk_req.drow  = k_reg - i_reg;

    nqbs_attack_unit u_attack (
        .req      (chk_req),
        .conflict (conflict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= nqbs_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        col_reg    <= col_next;
        r_reg      <= r_next;
        row_reg    <= row_next;
        column_reg <= column_next;
        found_reg  <= found_next;
        last_reg   <= last_next;
    end

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        col_next      = col_reg;
        r_next        = r_reg;
        m_tvalid_next = m_tvalid_reg;
        row_next      = row_reg;
        column_next   = column_reg;
        found_next    = found_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        wr_addr       = ADDR_W'(k_reg - 1'b1);
        wr_data       = col_reg;
        rd_addr       = '0;

        unique case (state_reg)
            nqbs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_next = in_size;
                    if ((in_size == '0) || ({1'b0, in_size} > CW'(MAX_QUEENS))) begin
                        // Nothing to search: report no placement at once.
                        row_next      = '0;
                        column_next   = '0;
                        found_next    = 1'b0;
                        last_next     = 1'b1;
                        m_tvalid_next = 1'b1;
                        state_next    = nqbs_pkg::ST_OUT_WAIT;
                    end else begin
                        k_next     = FW'(1);
                        col_next   = CW'(1);
                        state_next = nqbs_pkg::ST_TRY;
                    end
                end
            end

            nqbs_pkg::ST_TRY: begin
                if (col_reg > {1'b0, n_reg}) begin
                    // Row k has run out of columns: back up one row, or report no placement from row 1.
                    if (k_reg == FW'(1)) begin
                        row_next      = '0;
                        column_next   = '0;
                        found_next    = 1'b0;
                        last_next     = 1'b1;
                        m_tvalid_next = 1'b1;
                        state_next    = nqbs_pkg::ST_OUT_WAIT;
                    end else begin
                        k_next     = k_reg - 1'b1;
                        rd_addr    = ADDR_W'(k_reg - FW'(2));
                        state_next = nqbs_pkg::ST_BACK_LD;
                    end
                end else if (k_reg == FW'(1)) begin
                    // The first row has nothing above it to clash with.
                    wr_en = 1'b1;
                    if (k_reg == n_reg) begin
                        r_next     = FW'(1);
                        state_next = nqbs_pkg::ST_EMIT_RD;
                    end else begin
                        k_next   = k_reg + 1'b1;
                        col_next = CW'(1);
                    end
                end else begin
                    i_next     = FW'(1);
                    rd_addr    = '0;
                    state_next = nqbs_pkg::ST_CHECK;
                end
            end

            nqbs_pkg::ST_CHECK: begin
                if (conflict) begin
                    col_next   = col_reg + 1'b1;
                    state_next = nqbs_pkg::ST_TRY;
                end else if (i_reg == k_reg - 1'b1) begin
                    // Every earlier row passed: the candidate stands.
                    wr_en = 1'b1;
                    if (k_reg == n_reg) begin
                        r_next     = FW'(1);
                        state_next = nqbs_pkg::ST_EMIT_RD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        col_next   = CW'(1);
                        state_next = nqbs_pkg::ST_TRY;
                    end
                end else begin
                    i_next  = i_reg + 1'b1;
                    rd_addr = ADDR_W'(i_reg);
                end
            end

            nqbs_pkg::ST_BACK_LD: begin
                col_next   = rd_data + 1'b1;
                state_next = nqbs_pkg::ST_TRY;
            end

            nqbs_pkg::ST_EMIT_RD: begin
                rd_addr    = ADDR_W'(r_reg - 1'b1);
                state_next = nqbs_pkg::ST_EMIT_LD;
            end

            nqbs_pkg::ST_EMIT_LD: begin
                row_next      = r_reg;
                column_next   = rd_data[FW-1:0];
                found_next    = 1'b1;
                last_next     = (r_reg == n_reg);
                m_tvalid_next = 1'b1;
                state_next    = nqbs_pkg::ST_OUT_WAIT;
            end

            nqbs_pkg::ST_OUT_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (last_reg) begin
                        state_next = nqbs_pkg::ST_IDLE;
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = nqbs_pkg::ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = nqbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == nqbs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, found_reg, column_reg, row_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- hdl/nqbs_ram.sv -----
module nqbs_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/nqbs_attack_unit.sv -----
module nqbs_attack_unit (
    input  nqbs_pkg::chk_req_t req,
    output logic               conflict
);

    logic [nqbs_pkg::COL_W-1:0] dcol;

    // Absolute column distance; a queen on the same diagonal has it equal to
    // the row distance.
    always_comb begin
        if (req.col >= req.other) begin
            dcol = req.col - req.other;
        end else begin
            dcol = req.other - req.col;
        end
        conflict = (req.col == req.other) || ({1'b0, req.drow} == dcol);
    end

endmodule

// ----- hdl/nqbs_checker.sv -----
`include "n_queens_backtrack_solver_core_defines.svh"

module nqbs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nqbs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // A result waiting on the receiver stays offered.
    `NQBS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // Once a request is taken the block is busy with it.
    `NQBS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // No new request is taken while a result is still being delivered.
    `NQBS_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)

    // A report of no placement is always the only, and so the last, item.
    `NQBS_ASSERT_NOW(a_fail_is_last, aclk, aresetn, m_tvalid && !m_tdata[10],
                     m_tlast && (m_tdata[9:0] == 10'd0))

    // A placed queen always has a nonzero row and column.
    `NQBS_ASSERT_NOW(a_found_nonzero, aclk, aresetn, m_tvalid && m_tdata[10],
                     (m_tdata[4:0] != 5'd0) && (m_tdata[9:5] != 5'd0))

endmodule

bind n_queens_backtrack_solver_core nqbs_checker u_nqbs_checker (.*);

// ----- tb/queen_placement_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the solver, works out the expected placement for
// every accepted board size and compares each result item against it.
module queen_placement_checker #(
    parameter int unsigned MAX_QUEENS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [nqbs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [nqbs_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int unsigned                    fail_count,
    output int unsigned                    queens_pending
);

    localparam int unsigned FW    = nqbs_pkg::FIELD_W;
    localparam int unsigned MW    = nqbs_pkg::M_TDATA_W;
    localparam int unsigned PAD_W = MW - 2 * FW - 1;

    typedef struct packed {
        logic [FW-1:0] row;
        logic [FW-1:0] column;
        logic          found;
        logic          last;
    } queen_item_t;

    queen_item_t expected_queens[$];

    // Iterative backtracking search for the first placement on an n x n board.
    // Pushes one item per row, or a single all-zero item when none exists.
    function automatic void solve_board(input logic [FW-1:0] n);
        int unsigned col[MAX_QUEENS];
        int          k;
        int          i;
        int          dcol;
        bit          clash;
        queen_item_t q;
        queen_item_t none;
        none      = '0;
        none.last = 1'b1;
        if (n == 0 || n > MAX_QUEENS) begin
            expected_queens.push_back(none);
            return;
        end
        k      = 1;
        col[0] = 1;
        while (k >= 1) begin
            // Move the queen of row k right until no earlier queen attacks it.
            while (col[k-1] <= n) begin
                clash = 1'b0;
                for (i = 1; i < k; i++) begin
                    dcol = (col[k-1] >= col[i-1]) ? col[k-1] - col[i-1]
                                                  : col[i-1] - col[k-1];
                    if (dcol == 0 || dcol == k - i)
                        clash = 1'b1;
                end
                if (!clash)
                    break;
                col[k-1]++;
            end
            if (col[k-1] <= n) begin
                if (k == n) begin
                    for (i = 1; i <= n; i++) begin
                        q.row    = FW'(i);
                        q.column = FW'(col[i-1]);
                        q.found  = 1'b1;
                        q.last   = (i == n);
                        expected_queens.push_back(q);
                    end
                    return;
                end
                k++;
                col[k-1] = 0;
            end else begin
                k--;
            end
            if (k >= 1)
                col[k-1]++;
        end
        expected_queens.push_back(none);
    endfunction

    always @(posedge aclk) begin
        queen_item_t want;
        queen_item_t got;
        int unsigned errs;
        errs = 0;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                solve_board(s_tdata[FW-1:0]);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[FW-1:0], m_tdata[2*FW-1:FW],
                       m_tdata[2*FW], m_tlast};
                if (expected_queens.size() == 0) begin
                    $write("%0t: result with nothing expected:", $time);
                    $display(" row %0d column %0d found %0d last %0d",
                             got.row, got.column, got.found, got.last);
                    errs++;
                end else begin
                    want = expected_queens.pop_front();
                    if (got !== want) begin
                        $write("%0t: mismatch: expected row %0d column %0d found %0d last %0d,",
                               $time, want.row, want.column, want.found, want.last);
                        $display(" got row %0d column %0d found %0d last %0d",
                                 got.row, got.column, got.found, got.last);
                        errs++;
                    end
                end
                if (m_tdata[MW-1 -: PAD_W] !== '0) begin
                    $display("%0t: padding mismatch: expected 0, got %h",
                             $time, m_tdata[MW-1 -: PAD_W]);
                    errs++;
                end
            end
        end
        fail_count     <= fail_count + errs;
        queens_pending <= expected_queens.size();
    end

endmodule

// ----- tb/n_queens_backtrack_solver_core_test.sv -----
`timescale 1ns / 1ps

// Top of the solver testbench. It drives board sizes into the slave stream,
// pulls results from the master stream with random back-pressure, and leaves
// all prediction and comparison to the checker that sits beside the block.
module n_queens_backtrack_solver_core_test;

    localparam int unsigned MAX_QUEENS = 16;
    localparam int unsigned FW         = nqbs_pkg::FIELD_W;
    localparam int unsigned SW         = nqbs_pkg::S_TDATA_W;
    localparam int unsigned MW         = nqbs_pkg::M_TDATA_W;

    // A 16-queen board is the slowest search: well over a hundred thousand
    // candidate columns, each walking up to 15 earlier rows. No item moves on
    // either stream during a search, so the idle limit must cover a whole
    // search with a wide margin; a hung sequencer still ends the run.
    localparam int unsigned STALL_LIMIT = 20_000_000;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [SW-1:0]   s_tdata  = '0;   // [4:0] board_size
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [MW-1:0]   m_tdata;         // [4:0] row, [9:5] column, [10] found
    logic            m_tlast;         // last

    int unsigned fail_count;
    int unsigned queens_pending;

    // When set, both sides run back to back with no idle cycles at all.
    bit          no_idle = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned quiet_cycles = 0;

    n_queens_backtrack_solver_core #(
        .MAX_QUEENS (MAX_QUEENS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    queen_placement_checker #(
        .MAX_QUEENS (MAX_QUEENS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .queens_pending (queens_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: after every accepted result item, m_tready stays low for a
    // freshly drawn number of cycles. The stall also applies while the block
    // is still searching, so gaps land on every phase of its work.
    always @(posedge aclk) begin
        int unsigned d;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            hold_cycles <= 0;
        end else if (m_tvalid && m_tready) begin
            d = no_idle ? 0 : $urandom_range(0, 10);
            hold_cycles <= d;
            m_tready    <= (d == 0);
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= (hold_cycles == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither stream moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one board size after a random gap and returns at the edge where
    // it is accepted. With a zero gap s_tvalid simply stays high.
    task automatic send_board(input logic [FW-1:0] n);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SW'(n);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds the sender off until every expected result has arrived. The first
    // edge lets the checker register the item that was just accepted.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (queens_pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [FW-1:0] n;
        int unsigned   r;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: every board size up to MAX_QUEENS, which covers the
        // empty board, the unsolvable sizes two and three, and the largest
        // board. Sizes past MAX_QUEENS, including the all-ones value, must be
        // rejected without a search.
        for (int i = 0; i <= MAX_QUEENS; i++)
            send_board(FW'(i));
        send_board(FW'(MAX_QUEENS + 1));
        send_board('1);
        send_board(FW'(24));

        // Let everything drain once before the random part starts.
        drain_results();

        // Random part. Small boards dominate since big ones search for a long
        // time; the slowest sizes are drawn only now and then. Every 20 items
        // the run switches between random idling and back-to-back traffic.
        for (int i = 0; i < 100; i++) begin
            if (i % 20 == 0)
                no_idle = (((i / 20) % 2) != 0);
            if (i == 50)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 3)
                n = FW'($urandom_range(14, MAX_QUEENS));
            else if (r < 15)
                n = FW'($urandom_range(MAX_QUEENS + 1, 31));
            else if (r < 25)
                n = FW'($urandom_range(11, 13));
            else
                n = FW'($urandom_range(0, 10));
            send_board(n);
        end

        no_idle = 1'b0;
        drain_results();
        // Nothing can be in flight without a pending result, so a short tail
        // is enough to catch stray items.
        repeat (20) @(posedge aclk);

        if (fail_count == 0 && queens_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
